// File: design/sorted_table_binary_search_top_macros.svh
// Assertion macros for the sorted table search block.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH

// Checked outside reset.
`define STBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in reset as well.
`define STBS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/stbs_pkg.sv
// Package: sizes, types and helpers of the sorted table search block.
package stbs_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int KEY_BITS    = 8;
  localparam int IN_KEY_BITS = 8;
  localparam int POS_BITS    = 6;
  localparam int ADDR_BITS   = $clog2(MAX_ENTRIES);
  localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [POS_BITS-1:0]  pos_t;

  function automatic key_t mask_key(input logic [IN_KEY_BITS-1:0] k);
    return key_t'(k);
  endfunction

  // floor((lo + hi1 - 1) / 2), hi1 is the exclusive upper bound
  function automatic cnt_t mid_of(input cnt_t lo, input cnt_t hi1);
    logic [CNT_BITS:0] sum;
    sum = {1'b0, lo} + {1'b0, hi1} - {{CNT_BITS{1'b0}}, 1'b1};
    return sum[CNT_BITS:1];
  endfunction

endpackage

// File: design/stbs_req_if.sv
// Request channel: kind, key and last mark with valid/ready.
interface stbs_req_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [stbs_pkg::IN_KEY_BITS-1:0] key;
  logic                             last;

  modport source (output valid, kind, key, last, input ready);
  modport sink   (input valid, kind, key, last, output ready);
endinterface

// File: design/stbs_rsp_if.sv
// Response channel: found flag and sorted position with valid/ready.
interface stbs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [stbs_pkg::POS_BITS-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

// File: design/stbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sorted_table_binary_search_top.sv
// Top level: key table with load, selection sort and binary search.
//
// Channels: req carries kind, key and last; rsp carries found and position.
// A request moves when valid and ready are both high at a clock edge.
// A load request (kind 0) writes its key into the table; loads beyond the
// table capacity are dropped. A load after a closed set starts a new set.
// A load marked last closes the set and runs a selection sort through the
// table memory, with one memory read per compared entry and one write per
// swapped entry. req.ready stays low while the sort runs.
// A search request (kind 1) gives exactly one response. Each binary search
// probe is one memory read, and a search makes at most log2(depth) + 1
// probes before the response register is loaded. Loads give no response.
// The response register holds while rsp.ready is low; a new request is taken
// meanwhile, and a further search waits for the register to free up.
// Reset (rst, synchronous) empties the table and opens a new set; the table
// memory is not cleared and needs no clearing pass.
module sorted_table_binary_search_top (
  input logic clk,
  input logic rst,
  stbs_req_if.sink   req,
  stbs_rsp_if.source rsp
);
  import stbs_pkg::*;

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_SORT_START = 3'd1;
  localparam logic [2:0] S_SORT_HEAD  = 3'd2;
  localparam logic [2:0] S_SORT_SCAN  = 3'd3;
  localparam logic [2:0] S_SORT_SWAP  = 3'd4;
  localparam logic [2:0] S_SORT_SWAP2 = 3'd5;
  localparam logic [2:0] S_SRCH       = 3'd6;
  localparam logic [2:0] S_DONE       = 3'd7;

  localparam cnt_t ONE   = cnt_t'(1);
  localparam cnt_t DEPTH = cnt_t'(MAX_ENTRIES);

  logic [2:0] state, state_next;
  cnt_t       count, count_next;
  logic       load_open, load_open_next;
  cnt_t       i, i_next, j, j_next, best, best_next;
  key_t       bestval, bestval_next, vali, vali_next;
  cnt_t       lo, lo_next, hi1, hi1_next, mid, mid_next;
  key_t       skey, skey_next;
  logic       res_found, res_found_next;
  pos_t       res_pos, res_pos_next;
  logic       out_valid, out_valid_next;
  logic       found, found_next;
  pos_t       position, position_next;

  logic  we;
  addr_t waddr, raddr;
  key_t  wdata, rdata;

  cnt_t base, lo_c, hi1_c;
  key_t req_key;

  stbs_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.found    = found;
  assign rsp.position = position;
  assign req_key      = mask_key(req.key);
  assign base         = load_open ? count : '0;

  always_comb begin
    state_next     = state;
    count_next     = count;
    load_open_next = load_open;
    i_next         = i;
    j_next         = j;
    best_next      = best;
    bestval_next   = bestval;
    vali_next      = vali;
    lo_next        = lo;
    hi1_next       = hi1;
    mid_next       = mid;
    skey_next      = skey;
    res_found_next = res_found;
    res_pos_next   = res_pos;
    out_valid_next = out_valid && !rsp.ready;
    found_next     = found;
    position_next  = position;
    we             = 1'b0;
    waddr          = '0;
    wdata          = '0;
    raddr          = '0;
    lo_c           = lo;
    hi1_c          = hi1;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.kind == KIND_LOAD) begin
            if (base < DEPTH) begin
              we         = 1'b1;
              waddr      = base[ADDR_BITS-1:0];
              wdata      = req_key;
              count_next = base + ONE;
            end else begin
              count_next = base;
            end
            if (req.last) begin
              load_open_next = 1'b0;
              i_next         = '0;
              state_next     = S_SORT_START;
            end else begin
              load_open_next = 1'b1;
            end
          end else begin
            skey_next = req_key;
            lo_next   = '0;
            hi1_next  = count;
            if (count != '0) begin
              mid_next   = mid_of('0, count);
              raddr      = mid_next[ADDR_BITS-1:0];
              state_next = S_SRCH;
            end else begin
              res_found_next = 1'b0;
              res_pos_next   = '0;
              state_next     = S_DONE;
            end
          end
        end
      end
      S_SORT_START: begin
        if (i + ONE < count) begin
          raddr      = i[ADDR_BITS-1:0];
          state_next = S_SORT_HEAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SORT_HEAD: begin
        vali_next    = rdata;
        bestval_next = rdata;
        best_next    = i;
        j_next       = i + ONE;
        raddr        = j_next[ADDR_BITS-1:0];
        state_next   = S_SORT_SCAN;
      end
      S_SORT_SCAN: begin
        if (rdata < bestval) begin
          bestval_next = rdata;
          best_next    = j;
        end
        if (j + ONE < count) begin
          j_next = j + ONE;
          raddr  = j_next[ADDR_BITS-1:0];
        end else begin
          state_next = S_SORT_SWAP;
        end
      end
      S_SORT_SWAP: begin
        if (best != i) begin
          we         = 1'b1;
          waddr      = i[ADDR_BITS-1:0];
          wdata      = bestval;
          state_next = S_SORT_SWAP2;
        end else begin
          i_next     = i + ONE;
          state_next = S_SORT_START;
        end
      end
      S_SORT_SWAP2: begin
        we         = 1'b1;
        waddr      = best[ADDR_BITS-1:0];
        wdata      = vali;
        i_next     = i + ONE;
        state_next = S_SORT_START;
      end
      S_SRCH: begin
        if (rdata == skey) begin
          res_found_next = 1'b1;
          res_pos_next   = pos_t'(mid);
          state_next     = S_DONE;
        end else begin
          if (rdata > skey) begin
            hi1_c = mid;
          end else begin
            lo_c = mid + ONE;
          end
          lo_next  = lo_c;
          hi1_next = hi1_c;
          if (lo_c < hi1_c) begin
            mid_next = mid_of(lo_c, hi1_c);
            raddr    = mid_next[ADDR_BITS-1:0];
          end else begin
            res_found_next = 1'b0;
            res_pos_next   = '0;
            state_next     = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          found_next     = res_found;
          position_next  = res_pos;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      load_open <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      load_open <= load_open_next;
      out_valid <= out_valid_next;
    end
    i         <= i_next;
    j         <= j_next;
    best      <= best_next;
    bestval   <= bestval_next;
    vali      <= vali_next;
    lo        <= lo_next;
    hi1       <= hi1_next;
    mid       <= mid_next;
    skey      <= skey_next;
    res_found <= res_found_next;
    res_pos   <= res_pos_next;
    found     <= found_next;
    position  <= position_next;
  end

endmodule

// File: design/stbs_checker.sv
// Port-level assertions of the sorted table search block, bound to the top.
`include "sorted_table_binary_search_top_macros.svh"

module stbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          req_kind,
  input logic                          req_last,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_found,
  input logic [stbs_pkg::POS_BITS-1:0] rsp_position
);
  import stbs_pkg::*;

  `STBS_ASSERT_ALWAYS(a_rst_no_rsp, rst |=> !rsp_valid, "response valid after reset")
  `STBS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position), "stalled response changed")
  `STBS_ASSERT(a_miss_pos, rsp_valid && !rsp_found |-> rsp_position == '0, "miss with nonzero position")
  `STBS_ASSERT(a_search_busy, req_valid && req_ready && req_kind == KIND_SEARCH |=> !req_ready, "ready right after search request")
  `STBS_ASSERT(a_load_quick, req_valid && req_ready && req_kind == KIND_LOAD && !req_last |=> req_ready, "plain load not finished in one cycle")

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_kind     (req.kind),
  .req_last     (req.last),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_found    (rsp.found),
  .rsp_position (rsp.position)
);

// File: tb/sv/sorted_table_binary_search_top_tb.sv
`timescale 1ns / 1ps
// Testbench for the sorted key table: loads, sorts and searches against a local table.
module sorted_table_binary_search_top_tb;
  import stbs_pkg::*;

  typedef struct packed {
    logic found;
    pos_t position;
  } lookup_t;

  typedef struct {
    logic kind;
    key_t key;
    logic last;
    bit   typed;
    logic found;
    pos_t position;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  stbs_req_if req();
  stbs_rsp_if rsp();

  sorted_table_binary_search_top uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  key_t    sorted_keys[MAX_ENTRIES];
  int      key_count = 0;
  bit      set_open = 1'b1;
  lookup_t pending_lookups[$];

  int errors = 0;
  int n_loads = 0;
  int n_searches = 0;
  int n_sorts = 0;
  int n_hits = 0;
  bit steady = 1'b0;
  int gap_odds = 4;

  stim_row_t directed_rows[24] = '{
    '{KIND_SEARCH, 8'd0,   1'b0, 1'b1, 1'b0, 6'd0},
    '{KIND_SEARCH, 8'd255, 1'b1, 1'b1, 1'b0, 6'd0},
    '{KIND_LOAD,   8'd255, 1'b0, 1'b0, 1'b0, 6'd0},
    '{KIND_LOAD,   8'd0,   1'b0, 1'b0, 1'b0, 6'd0},
    '{KIND_LOAD,   8'd128, 1'b0, 1'b0, 1'b0, 6'd0},
    '{KIND_LOAD,   8'd7,   1'b1, 1'b0, 1'b0, 6'd0},
    '{KIND_SEARCH, 8'd0,   1'b0, 1'b1, 1'b1, 6'd0},
    '{KIND_SEARCH, 8'd255, 1'b0, 1'b1, 1'b1, 6'd3},
    '{KIND_SEARCH, 8'd7,   1'b0, 1'b1, 1'b1, 6'd1},
    '{KIND_SEARCH, 8'd128, 1'b0, 1'b0, 1'b0, 6'd0},
    '{KIND_SEARCH, 8'd100, 1'b0, 1'b1, 1'b0, 6'd0},
    '{KIND_SEARCH, 8'd1,   1'b1, 1'b0, 1'b0, 6'd0},
    '{KIND_LOAD,   8'd200, 1'b0, 1'b0, 1'b0, 6'd0},
    '{KIND_LOAD,   8'd50,  1'b0, 1'b0, 1'b0, 6'd0},
    '{KIND_SEARCH, 8'd50,  1'b0, 1'b0, 1'b0, 6'd0},
    '{KIND_SEARCH, 8'd200, 1'b0, 1'b0, 1'b0, 6'd0},
    '{KIND_LOAD,   8'd9,   1'b0, 1'b0, 1'b0, 6'd0},
    '{KIND_LOAD,   8'd9,   1'b0, 1'b0, 1'b0, 6'd0},
    '{KIND_LOAD,   8'd9,   1'b1, 1'b0, 1'b0, 6'd0},
    '{KIND_SEARCH, 8'd9,   1'b0, 1'b0, 1'b0, 6'd0},
    '{KIND_SEARCH, 8'd200, 1'b0, 1'b0, 1'b0, 6'd0},
    '{KIND_LOAD,   8'd42,  1'b1, 1'b0, 1'b0, 6'd0},
    '{KIND_SEARCH, 8'd42,  1'b0, 1'b1, 1'b1, 6'd0},
    '{KIND_SEARCH, 8'd43,  1'b0, 1'b1, 1'b0, 6'd0}
  };

  initial begin
    forever #2 clk = ~clk;
  end

  // Table tracking: load/sort on loads, binary search on searches.
  function automatic lookup_t track_request(logic kind, key_t k, logic last);
    lookup_t r;
    key_t    swap;
    int      lo, hi, mid, best;
    r = '0;
    if (kind == KIND_LOAD) begin
      n_loads++;
      if (!set_open) begin
        key_count = 0;
        set_open = 1'b1;
      end
      if (key_count < MAX_ENTRIES) begin
        sorted_keys[key_count] = k;
        key_count++;
      end
      if (last) begin
        for (lo = 0; lo + 1 < key_count; lo++) begin
          best = lo;
          for (hi = lo + 1; hi < key_count; hi++)
            if (sorted_keys[hi] < sorted_keys[best]) best = hi;
          if (best != lo) begin
            swap = sorted_keys[lo];
            sorted_keys[lo] = sorted_keys[best];
            sorted_keys[best] = swap;
          end
        end
        set_open = 1'b0;
        n_sorts++;
      end
    end else begin
      n_searches++;
      lo = 0;
      hi = key_count - 1;
      while (lo <= hi && !r.found) begin
        mid = (lo + hi) / 2;
        if (sorted_keys[mid] == k) begin
          r.found = 1'b1;
          r.position = pos_t'(mid);
        end else if (sorted_keys[mid] > k) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
      if (r.found) n_hits++;
    end
    return r;
  endfunction

  task automatic send_request(input logic kind, input key_t k, input logic last,
                              input bit typed, input logic found, input pos_t position);
    lookup_t predicted;
    lookup_t given;
    if (!steady && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      req.valid <= 1'b0;
      req.kind <= logic'($urandom_range(0, 1));
      req.key <= key_t'($urandom);
      req.last <= logic'($urandom_range(0, 1));
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.kind <= kind;
    req.key <= k;
    req.last <= last;
    do @(posedge clk); while (req.ready !== 1'b1);
    predicted = track_request(kind, k, last);
    given.found = found;
    given.position = position;
    if (kind == KIND_SEARCH) pending_lookups = {pending_lookups, (typed ? given : predicted)};
  endtask

  task automatic wait_for_responses();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_lookups.size() != 0);
  endtask

  always @(posedge clk) begin : check_responses
    lookup_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_lookups.size() == 0) begin
        $error("response with no search pending: found %0d position %0d",
               rsp.found, rsp.position);
        errors++;
      end else begin
        want = pending_lookups.pop_front();
        if (rsp.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, rsp.found);
          errors++;
        end
        if (rsp.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, rsp.position);
          errors++;
        end
      end
    end
  end

  initial begin
    rsp.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!steady && $urandom_range(0, 2) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    key_t k;
    key_t loaded[$];
    int   issued, set_no, n, m, j, key_hi;
    bit   open_end;
    issued = 0;
    set_no = 0;
    req.valid <= 1'b0;
    req.kind <= KIND_LOAD;
    req.key <= '0;
    req.last <= 1'b0;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].key, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].found,
                   directed_rows[i].position);
    wait_for_responses();

    // first set overflows the table and its last mark lands on a dropped key
    while (issued < 400) begin
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 4;
      if (set_no == 0) n = MAX_ENTRIES + 6;
      else if ($urandom_range(0, 14) == 0) n = $urandom_range(MAX_ENTRIES - 4, MAX_ENTRIES + 4);
      else n = $urandom_range(1, 12);
      key_hi = ($urandom_range(0, 3) == 0) ? 15 : 255;
      open_end = (set_no != 0) && ($urandom_range(0, 7) == 0);
      loaded.delete();
      for (j = 0; j < n; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(KIND_SEARCH, key_t'($urandom), logic'($urandom_range(0, 1)),
                       1'b0, 1'b0, '0);
          issued++;
        end
        k = key_t'($urandom_range(0, key_hi));
        loaded = {loaded, k};
        send_request(KIND_LOAD, k, logic'((j == n - 1) && !open_end), 1'b0, 1'b0, '0);
        issued++;
      end
      m = $urandom_range(2, 10);
      for (j = 0; j < m; j++) begin
        if ($urandom_range(0, 9) < 7) k = loaded[$urandom_range(0, loaded.size() - 1)];
        else k = key_t'($urandom_range(0, key_hi));
        send_request(KIND_SEARCH, k, logic'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
        issued++;
      end
      if ($urandom_range(0, 5) == 0) wait_for_responses();
      steady = (issued >= 340);
      set_no++;
    end

    wait_for_responses();
    repeat (64) @(posedge clk);
    $display("Covered %0d loads over %0d sorted sets and %0d searches (%0d hits).",
             n_loads, n_sorts, n_searches, n_hits);
    $display("Sets ranged from one key to past capacity, with searches on open sets.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
